// ===== design/pli_pkg.sv =====
// Package for the piecewise-linear interpolator: ops, FSM states, sizes.
// No dependencies; used by the top level and the testbench.
package pli_pkg;

    localparam int TABLE_DEPTH_DEF = 256;
    localparam int DATA_W = 32;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_QUERY  = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WALK_RD,
        ST_WALK_CHK,
        ST_SEG_RD0,
        ST_SEG_RD1,
        ST_SEG_WAIT,
        ST_MUL,
        ST_DIV,
        ST_FIN,
        ST_OUT
    } state_t;

endpackage

// ===== design/piecewise_linear_interp.sv =====
// Top level of the piecewise-linear interpolator.
// Depends on pli_pkg and pli_ram (two instances: breakpoint x and y).
//
// One beat in carries an op. Clear and append give no result. A query walks
// the stored breakpoints from the walk pointer (one RAM read and one compare
// for each), reads the two breakpoints of the chosen segment, forms one 33x33
// product and then runs a 64-bit restoring divide, one quotient bit per cycle.
// Out-of-table queries finish after the walk. The result is held in an output
// register until it is taken; the next beat is accepted only in the idle state
// and once that register is empty.
// Breakpoint memories need no clearing: only entries below the count are read.
module piecewise_linear_interp #(
    parameter int TABLE_DEPTH = pli_pkg::TABLE_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         op,
    input  logic signed [31:0] point_x,
    input  logic signed [31:0] point_y,
    input  logic signed [31:0] query_x,
    input  logic               batch_start,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] value,
    output logic               no_value,
    output logic [7:0]         segment,
    output logic               saturated
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    pli_pkg::state_t state_reg, state_next;

    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] ptr_reg, ptr_next;
    logic signed [31:0] q_reg, q_next;
    logic signed [32:0] x0_reg, x0_next, y0_reg, y0_next;
    logic signed [32:0] x1_reg, x1_next, y1_reg, y1_next;
    logic [CW-1:0] seg_reg, seg_next;
    logic [63:0] num_reg, num_next;
    logic [32:0] den_reg, den_next;
    logic [64:0] rem_reg, rem_next;
    logic [6:0]  bit_reg, bit_next;
    logic        neg_reg, neg_next;

    logic               ov_reg, ov_next;
    logic signed [31:0] val_reg, val_next;
    logic               nv_reg, nv_next;
    logic [7:0]         sg_reg, sg_next;
    logic               sat_reg, sat_next;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [31:0]   rx, ry;

    pli_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_ram_x (
        .clk(clk), .we(we), .waddr(waddr), .wdata(point_x),
        .raddr(raddr), .rdata(rx)
    );
    pli_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_ram_y (
        .clk(clk), .we(we), .waddr(waddr), .wdata(point_y),
        .raddr(raddr), .rdata(ry)
    );

    assign waddr     = count_reg[AW-1:0];
    assign in_ready  = (state_reg == pli_pkg::ST_IDLE) && !ov_reg;
    assign out_valid = ov_reg;
    assign value     = val_reg;
    assign no_value  = nv_reg;
    assign segment   = sg_reg;
    assign saturated = sat_reg;

    logic        accept;
    logic signed [32:0] dx, dq, dy;
    logic [32:0] mdq, mdy, mdx;
    logic [65:0] prod;
    logic [64:0] trial;
    logic [63:0] quot;
    logic signed [65:0] rsum;

    assign accept = in_valid && in_ready;

    always_comb
    begin
        dx   = x1_reg - x0_reg;
        dq   = 33'(q_reg) - x0_reg;
        dy   = y1_reg - y0_reg;
        mdq  = dq[32] ? 33'(-dq) : 33'(dq);
        mdy  = dy[32] ? 33'(-dy) : 33'(dy);
        mdx  = dx[32] ? 33'(-dx) : 33'(dx);
        prod = 66'(mdq) * 66'(mdy);
        trial = {rem_reg[63:0], num_reg[63]} - 65'(den_reg);
        // clamp the quotient at 2^40: keeps y0 +- quot inside 66 bits sanely
        quot = (rem_reg[63:0] > 64'h100_0000_0000) ? 64'h100_0000_0000 : rem_reg[63:0];
        rsum = neg_reg ? 66'(y0_reg) - 66'(quot) : 66'(y0_reg) + 66'(quot);
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        ptr_next   = ptr_reg;
        q_next     = q_reg;
        x0_next    = x0_reg;
        y0_next    = y0_reg;
        x1_next    = x1_reg;
        y1_next    = y1_reg;
        seg_next   = seg_reg;
        num_next   = num_reg;
        den_next   = den_reg;
        rem_next   = rem_reg;
        bit_next   = bit_reg;
        neg_next   = neg_reg;
        ov_next    = ov_reg;
        val_next   = val_reg;
        nv_next    = nv_reg;
        sg_next    = sg_reg;
        sat_next   = sat_reg;
        we         = 1'b0;
        raddr      = ptr_reg[AW-1:0];

        if (ov_reg && out_ready)
        begin
            ov_next = 1'b0;
        end

        unique case (state_reg)
            pli_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (pli_pkg::op_t'(op))
                        pli_pkg::OP_CLEAR:
                        begin
                            count_next = '0;
                            ptr_next   = '0;
                        end
                        pli_pkg::OP_APPEND:
                        begin
                            if (count_reg < DEPTH_C)
                            begin
                                we         = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        pli_pkg::OP_QUERY:
                        begin
                            q_next = query_x;
                            if (batch_start)
                            begin
                                ptr_next = '0;
                            end
                            else if (ptr_reg > count_reg)
                            begin
                                ptr_next = count_reg;
                            end
                            state_next = pli_pkg::ST_WALK_RD;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            pli_pkg::ST_WALK_RD:
            begin
                // issue read of knot at the pointer, or finish the walk
                if (ptr_reg < count_reg)
                begin
                    state_next = pli_pkg::ST_WALK_CHK;
                end
                else
                begin
                    // past end: only an exact hit on the last knot has a value
                    seg_next   = count_reg - CW'(2);
                    raddr      = AW'(count_reg - 1'b1);
                    state_next = (count_reg >= CW'(2)) ? pli_pkg::ST_SEG_WAIT
                                                        : pli_pkg::ST_FIN;
                    nv_next    = 1'b1;
                    if (count_reg < CW'(2))
                    begin
                        bit_next = '0;
                    end
                end
            end
            pli_pkg::ST_WALK_CHK:
            begin
                if ($signed(rx) <= q_reg)
                begin
                    ptr_next   = ptr_reg + 1'b1;
                    state_next = pli_pkg::ST_WALK_RD;
                end
                else if (ptr_reg == '0)
                begin
                    nv_next    = 1'b1;
                    state_next = pli_pkg::ST_FIN;
                end
                else
                begin
                    seg_next   = ptr_reg - 1'b1;
                    raddr      = AW'(ptr_reg - 1'b1);
                    nv_next    = 1'b0;
                    state_next = pli_pkg::ST_SEG_RD0;
                end
            end
            pli_pkg::ST_SEG_WAIT:
            begin
                // rx holds the last knot x: check for exact hit
                if ($signed(rx) == q_reg)
                begin
                    nv_next    = 1'b0;
                    raddr      = seg_reg[AW-1:0];
                    state_next = pli_pkg::ST_SEG_RD0;
                end
                else
                begin
                    state_next = pli_pkg::ST_FIN;
                end
            end
            pli_pkg::ST_SEG_RD0:
            begin
                x0_next    = 33'($signed(rx));
                y0_next    = 33'($signed(ry));
                raddr      = AW'(seg_reg + 1'b1);
                state_next = pli_pkg::ST_SEG_RD1;
            end
            pli_pkg::ST_SEG_RD1:
            begin
                x1_next    = 33'($signed(rx));
                y1_next    = 33'($signed(ry));
                state_next = pli_pkg::ST_MUL;
            end
            pli_pkg::ST_MUL:
            begin
                if (dx == '0)
                begin
                    nv_next    = 1'b1;
                    state_next = pli_pkg::ST_FIN;
                end
                else
                begin
                    num_next   = prod[63:0];
                    den_next   = mdx;
                    rem_next   = '0;
                    bit_next   = '0;
                    neg_next   = (prod != '0) && ((dq[32] ^ dy[32]) ^ dx[32]);
                    state_next = pli_pkg::ST_DIV;
                end
            end
            pli_pkg::ST_DIV:
            begin
                // restoring divide: rem_reg[63:0] collects quotient bits once done
                // hold the partial remainder in rem while num shifts the dividend out
                num_next = {num_reg[62:0], !trial[64]};
                rem_next = trial[64] ? {rem_reg[63:0], num_reg[63]} : trial;
                bit_next = bit_reg + 1'b1;
                if (bit_reg == 7'd63)
                begin
                    rem_next   = {1'b0, num_reg[62:0], !trial[64]};
                    state_next = pli_pkg::ST_FIN;
                end
            end
            pli_pkg::ST_FIN:
            begin
                if (!ov_reg || out_ready)
                begin
                    ov_next = 1'b1;
                    if (nv_reg)
                    begin
                        val_next = '0;
                        sg_next  = '0;
                        sat_next = 1'b0;
                    end
                    else
                    begin
                        sg_next = seg_reg[7:0];
                        if (rsum > 66'sh0_7FFF_FFFF)
                        begin
                            val_next = 32'sh7FFF_FFFF;
                            sat_next = 1'b1;
                        end
                        else if (rsum < -66'sh0_8000_0000)
                        begin
                            val_next = 32'sh8000_0000;
                            sat_next = 1'b1;
                        end
                        else
                        begin
                            val_next = rsum[31:0];
                            sat_next = 1'b0;
                        end
                    end
                    state_next = pli_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pli_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pli_pkg::ST_IDLE;
            count_reg <= '0;
            ptr_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ptr_reg   <= ptr_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        x0_reg  <= x0_next;
        y0_reg  <= y0_next;
        x1_reg  <= x1_next;
        y1_reg  <= y1_next;
        seg_reg <= seg_next;
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
        bit_reg <= bit_next;
        neg_reg <= neg_next;
        val_reg <= val_next;
        nv_reg  <= nv_next;
        sg_reg  <= sg_next;
        sat_reg <= sat_next;
    end

endmodule

// ===== design/pli_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module pli_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== design/pli_checker.sv =====
// Port-level checks for piecewise_linear_interp, bound to the top level.
// Depends only on the top level's ports.
module pli_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [31:0] value,
    input logic               no_value,
    input logic [7:0]         segment,
    input logic               saturated
);

    a_nv_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && no_value |-> value == '0 && segment == '0 && !saturated)
        else $error("no-value beat carries nonzero fields");

    a_sat_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated |-> value == 32'sh7FFF_FFFF || value == 32'sh8000_0000)
        else $error("saturated beat not clamped");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(value))
        else $error("result dropped while stalled");

    a_no_accept_pending: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input taken while result pending");

endmodule

bind piecewise_linear_interp pli_checker u_pli_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .value(value),
    .no_value(no_value), .segment(segment), .saturated(saturated)
);

// ===== tb/tb_piecewise_linear_interp.sv =====
// Testbench for piecewise_linear_interp: directed table, then random batches.
// Depends on pli_pkg and the block's RTL; predicts every query result itself.
module tb_piecewise_linear_interp;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = pli_pkg::TABLE_DEPTH_DEF;
    localparam int WATCHDOG_LIMIT = 20000;

    // one query result as the block reports it
    typedef struct packed {
        logic signed [31:0] value;
        logic               no_value;
        logic [7:0]         segment;
        logic               saturated;
    } interp_res_t;

    // one input beat
    typedef struct packed {
        pli_pkg::op_t       op;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] qx;
        logic               bstart;
    } pli_beat_t;

    // directed row: beat plus optional typed-in result
    typedef struct {
        pli_beat_t   beat;
        bit          has_fixed;
        interp_res_t fixed;
    } dir_row_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [1:0]         op;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] query_x;
    logic               batch_start;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] value;
    logic               no_value;
    logic [7:0]         segment;
    logic               saturated;

    piecewise_linear_interp dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .op          (op),
        .point_x     (point_x),
        .point_y     (point_y),
        .query_x     (query_x),
        .batch_start (batch_start),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .value       (value),
        .no_value    (no_value),
        .segment     (segment),
        .saturated   (saturated)
    );

    // Predictor state: own copy of the breakpoint table and walk pointer.
    logic signed [31:0] bp_x [DEPTH];
    logic signed [31:0] bp_y [DEPTH];
    int unsigned        bp_count;
    int unsigned        walk_ptr;

    interp_res_t pending_results [$];
    int          err_count;
    int          beats_sent;
    int          queries_checked;
    int          sat_seen;
    int          nov_seen;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          stall_cycles;
    bit          timed_out;

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // Compute the expected result of one beat and update the predictor
    // table. Return 1 when the beat produces a result.
    function automatic bit interp_predict(input pli_beat_t b, output interp_res_t r);
        int                 seg;
        logic signed [63:0] x0, x1, y0, y1, dx, dq, dy, sum;
        logic [63:0]        mdq, mdy, mdx, num, quot;
        bit                 neg;
        r = '{value: '0, no_value: 1'b1, segment: '0, saturated: 1'b0};
        case (b.op)
            pli_pkg::OP_CLEAR:
            begin
                bp_count = 0;
                walk_ptr = 0;
                return 0;
            end
            pli_pkg::OP_APPEND:
            begin
                if (bp_count < DEPTH)
                begin
                    bp_x[bp_count] = b.px;
                    bp_y[bp_count] = b.py;
                    bp_count++;
                end
                return 0;
            end
            pli_pkg::OP_QUERY: ;
            default: return 0;
        endcase
        if (b.bstart)
            walk_ptr = 0;
        if (walk_ptr > bp_count)
            walk_ptr = bp_count;
        while (walk_ptr < bp_count && bp_x[walk_ptr] <= b.qx)
            walk_ptr++;
        seg = -1;
        if (walk_ptr < bp_count)
            seg = int'(walk_ptr) - 1;
        else if (bp_count >= 2 && bp_x[bp_count - 1] == b.qx)
            seg = int'(bp_count) - 2;
        if (seg < 0)
            return 1;
        x0 = bp_x[seg];
        x1 = bp_x[seg + 1];
        y0 = bp_y[seg];
        y1 = bp_y[seg + 1];
        dx = x1 - x0;
        if (dx == 0)
            return 1;
        dq = 64'(b.qx) - x0;
        dy = y1 - y0;
        mdq = dq < 0 ? -dq : dq;
        mdy = dy < 0 ? -dy : dy;
        mdx = dx < 0 ? -dx : dx;
        num = mdq * mdy;
        quot = num / mdx;
        neg = ((dq < 0) != (dy < 0)) != (dx < 0);
        if (num == 0)
            neg = 1'b0;
        if (quot > (64'd1 << 40))
            quot = 64'd1 << 40;
        sum = neg ? y0 - $signed(quot) : y0 + $signed(quot);
        r.no_value = 1'b0;
        r.segment = seg[7:0];
        if (sum > 64'sd2147483647)
        begin
            sum = 64'sd2147483647;
            r.saturated = 1'b1;
        end
        else if (sum < -64'sd2147483648)
        begin
            sum = -64'sd2147483648;
            r.saturated = 1'b1;
        end
        r.value = sum[31:0];
        return 1;
    endfunction

    // Present one beat, hold it until accepted, queue the expectation.
    task automatic send_beat(input pli_beat_t b, input bit has_fixed, input interp_res_t fixed);
        interp_res_t r;
        bit          gives;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        op          <= b.op;
        point_x     <= b.px;
        point_y     <= b.py;
        query_x     <= b.qx;
        batch_start <= b.bstart;
        do
            @(posedge clk);
        while (!in_ready);
        gives = interp_predict(b, r);
        if (has_fixed && gives && r !== fixed)
        begin
            $error("directed row disagrees with predictor: exp %h got %h", fixed, r);
            err_count++;
        end
        if (gives)
            pending_results.push_back(has_fixed ? fixed : r);
        beats_sent++;
    endtask

    function automatic pli_beat_t mk(pli_pkg::op_t o, logic signed [31:0] px,
                                     logic signed [31:0] py,
                                     logic signed [31:0] qx, logic bs);
        return '{op: o, px: px, py: py, qx: qx, bstart: bs};
    endfunction

    function automatic interp_res_t nov();
        return '{value: '0, no_value: 1'b1, segment: '0, saturated: 1'b0};
    endfunction

    function automatic interp_res_t hit(logic signed [31:0] v, logic [7:0] s, logic sat);
        return '{value: v, no_value: 1'b0, segment: s, saturated: sat};
    endfunction

    // Receiver: stall at random, compare each accepted result field by field.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result with nothing expected: value %h", value);
                    err_count++;
                end
                else
                begin
                    interp_res_t e;
                    e = pending_results.pop_front();
                    if (value !== e.value)
                    begin
                        $error("value: exp %h got %h", e.value, value);
                        err_count++;
                    end
                    if (no_value !== e.no_value)
                    begin
                        $error("no_value: exp %b got %b", e.no_value, no_value);
                        err_count++;
                    end
                    if (segment !== e.segment)
                    begin
                        $error("segment: exp %0d got %0d", e.segment, segment);
                        err_count++;
                    end
                    if (saturated !== e.saturated)
                    begin
                        $error("saturated: exp %b got %b", e.saturated, saturated);
                        err_count++;
                    end
                    queries_checked++;
                    sat_seen += e.saturated;
                    nov_seen += e.no_value;
                end
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: count cycles with no beat accepted on either side.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT && !timed_out)
        begin
            timed_out = 1'b1;
            $display("watchdog expired with %0d results pending", pending_results.size());
            $display("tb_piecewise_linear_interp: errors");
            $finish;
        end
    end

    function automatic logic signed [31:0] rnd32();
        return $urandom();
    endfunction

    // One random batch: clear, append a mostly sorted table with random spacing,
    // then random queries over and around it.
    task automatic random_batch();
        int                 n;
        int                 nq;
        logic signed [63:0] xs;
        logic signed [31:0] lo, hi, q;
        logic signed [31:0] y;
        logic               bs;
        interp_res_t        dummy;
        n = ($urandom_range(9) == 0) ? $urandom_range(8) : $urandom_range(2, 8);
        send_beat(mk(pli_pkg::OP_CLEAR, rnd32(), rnd32(), rnd32(), $urandom_range(1)), 0,
                  dummy);
        xs = $signed(64'($signed(rnd32()))) >>> $urandom_range(31);
        lo = xs[31:0];
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(3))
                0: y = rnd32();
                1: y = $signed(rnd32()) >>> 8;
                2: y = {$urandom_range(1) ? 1'b0 : 1'b1, 31'h7fff_ff00 | 31'($urandom_range(255))};
                default: y = $signed(rnd32()) >>> 20;
            endcase
            if (xs > 64'sd2147483647)
                xs = 64'sd2147483647;
            // occasional unsorted or repeated breakpoints
            if ($urandom_range(19) == 0)
                send_beat(mk(pli_pkg::OP_APPEND, rnd32(), y, rnd32(), 0), 0, dummy);
            else
                send_beat(mk(pli_pkg::OP_APPEND, xs[31:0], y, rnd32(), 0), 0, dummy);
            hi = xs[31:0];
            case ($urandom_range(5))
                0: xs = xs;
                1: xs = xs + 1;
                2: xs = xs + $urandom_range(1 << 16);
                default: xs = xs + ($urandom() >> $urandom_range(31));
            endcase
        end
        nq = $urandom_range(1, 10);
        q = lo - $urandom_range(3);
        for (int i = 0; i < nq; i++)
        begin
            if ($urandom_range(7) == 0)
                q = rnd32();
            else if ($urandom_range(5) == 0)
                q = hi;
            else if (hi > lo)
                q = lo + 32'($urandom() % (64'(hi) - 64'(lo) + 2));
            if ($urandom_range(15) == 0)
                send_beat(mk(pli_pkg::OP_NONE, rnd32(), rnd32(), rnd32(), 1), 0, dummy);
            bs = (i == 0) | ($urandom_range(9) == 0);
            send_beat(mk(pli_pkg::OP_QUERY, rnd32(), rnd32(), q, bs), 0, dummy);
        end
    endtask

    dir_row_t    dir_rows [$];
    interp_res_t none_r;

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        op = pli_pkg::OP_NONE;
        point_x = '0;
        point_y = '0;
        query_x = '0;
        batch_start = 1'b0;
        err_count = 0;
        beats_sent = 0;
        queries_checked = 0;
        sat_seen = 0;
        nov_seen = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        stall_cycles = 0;
        timed_out = 1'b0;
        bp_count = 0;
        walk_ptr = 0;
        none_r = nov();

        // Directed rows: empty table, single point, extremes, saturation,
        // zero-width segment, pointer past query, full table via fill below.
        dir_rows = '{
            '{mk(pli_pkg::OP_QUERY,  0, 0, 0, 1), 1, nov()},
            '{mk(pli_pkg::OP_APPEND, 0, 32'sh7fffffff, 0, 0), 0, none_r},
            '{mk(pli_pkg::OP_QUERY,  0, 0, 0, 1), 1, nov()},
            '{mk(pli_pkg::OP_APPEND, 32'sh00010000, 32'sh80000000, 0, 0), 0, none_r},
            '{mk(pli_pkg::OP_QUERY,  0, 0, 0, 1), 1, hit(32'sh7fffffff, 0, 0)},
            '{mk(pli_pkg::OP_QUERY,  0, 0, 32'sh00008000, 0), 0, none_r},
            '{mk(pli_pkg::OP_QUERY,  0, 0, 32'sh00010000, 0), 1, hit(32'sh80000000, 0, 0)},
            '{mk(pli_pkg::OP_QUERY,  0, 0, 32'sh00010001, 0), 1, nov()},
            '{mk(pli_pkg::OP_QUERY,  0, 0, -1, 1), 1, nov()},
            '{mk(pli_pkg::OP_NONE,   -1, -1, -1, 1), 0, none_r},
            '{mk(pli_pkg::OP_CLEAR,  -1, -1, -1, 1), 0, none_r},
            '{mk(pli_pkg::OP_APPEND, 32'sh80000000, 32'sh80000000, 0, 0), 0, none_r},
            '{mk(pli_pkg::OP_APPEND, 32'sh80000001, 32'sh7fffffff, 0, 0), 0, none_r},
            '{mk(pli_pkg::OP_APPEND, 32'sh7fffffff, 32'sh80000000, 0, 0), 0, none_r},
            '{mk(pli_pkg::OP_QUERY,  0, 0, 32'sh7fffffff, 1), 1, hit(32'sh80000000, 1, 0)},
            '{mk(pli_pkg::OP_QUERY,  0, 0, 32'sh80000000, 1), 1, hit(32'sh80000000, 0, 0)},
            '{mk(pli_pkg::OP_QUERY,  0, 0, 32'sh80000001, 0), 0, none_r},
            '{mk(pli_pkg::OP_QUERY,  0, 0, 32'sh80000000, 0), 0, none_r},
            '{mk(pli_pkg::OP_CLEAR,  0, 0, 0, 0), 0, none_r},
            '{mk(pli_pkg::OP_APPEND, 0, 0, 0, 0), 0, none_r},
            '{mk(pli_pkg::OP_APPEND, 1, 32'sh7fffffff, 0, 0), 0, none_r},
            '{mk(pli_pkg::OP_APPEND, 1, 0, 0, 0), 0, none_r},
            '{mk(pli_pkg::OP_APPEND, 32'sh7fffffff, 32'sh7fffffff, 0, 0), 0, none_r},
            '{mk(pli_pkg::OP_QUERY,  0, 0, 32'sh40000000, 1), 0, none_r},
            '{mk(pli_pkg::OP_QUERY,  0, 0, 1, 1), 0, none_r}
        };

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_beat(dir_rows[i].beat, dir_rows[i].has_fixed, dir_rows[i].fixed);

        // Fill the table past its depth; extra appends must be dropped.
        send_beat(mk(pli_pkg::OP_CLEAR, 0, 0, 0, 0), 0, none_r);
        for (int i = 0; i < DEPTH + 3; i++)
            send_beat(mk(pli_pkg::OP_APPEND, i << 8, $signed(rnd32()) >>> 4, 0, 0), 0, none_r);
        send_beat(mk(pli_pkg::OP_QUERY, 0, 0, ((DEPTH - 1) << 8), 1), 0, none_r);
        send_beat(mk(pli_pkg::OP_QUERY, 0, 0, (DEPTH << 8), 0), 0, none_r);
        send_beat(mk(pli_pkg::OP_QUERY, 0, 0, 32'h7f, 1), 0, none_r);

        // Random batches across idle/stall phases.
        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
                3: begin send_idle_pct = 20; recv_stall_pct = 20; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            repeat (18) random_batch();
        end
        in_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);

        $display("%0d beats sent, %0d queries checked (%0d no-value, %0d saturated)",
                 beats_sent, queries_checked, nov_seen, sat_seen);
        if (err_count == 0 && pending_results.size() == 0)
            $display("tb_piecewise_linear_interp: clean");
        else
            $display("tb_piecewise_linear_interp: errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/pli_pkg.sv
design/pli_ram.sv
design/piecewise_linear_interp.sv
design/pli_checker.sv
tb/tb_piecewise_linear_interp.sv
